// ----- rtl/core/pqd_pkg.sv -----
// ----------------------------------------------------------------------------
// pqd_pkg
// Shared widths, constants and transfer types of the packed quaternion decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pqd_pkg;

    // Packed word layout.
    localparam int PACKED_W    = 40;
    localparam int FIELD_W     = 12;
    localparam int N_FIELDS    = 3;
    localparam int SLOT_LSB    = 36;
    localparam int NEG_BIT     = 38;

    // Component scaling: q = floor((d * K + 2^17) / 2^18), d = field - 2049.
    localparam int D_W         = FIELD_W + 1;
    localparam int K_W         = 22;
    localparam int PROD_W      = D_W + K_W;
    localparam int FRAC_SHIFT  = 18;
    localparam logic signed [D_W-1:0]    FIELD_BIAS = 13'sd2049;
    localparam logic signed [K_W-1:0]    SCALE_K    = 22'sd1483636;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 35'sd131072;

    // Scaled component, its square and the radicand.
    localparam int Q_W         = 15;
    localparam int SQ_W        = 28;
    localparam int SUM_W       = 30;
    localparam int RAD_W       = 29;
    localparam logic [SUM_W-1:0] ONE_Q28 = 30'd268435456;

    // Square root datapath.
    localparam int SQRT_W      = 30;
    localparam int SQRT_STEPS  = 15;
    localparam int SQRT_MSB    = 28;
    localparam int SQRT_STEPS_PER_STAGE = 4;

    // Result component width, signed Q1.14.
    localparam int COMP_W      = 16;

    typedef struct packed {
        logic [SQRT_W-1:0] rem;
        logic [SQRT_W-1:0] root;
    } t_sqrt;

    // Everything that rides alongside the square root.
    typedef struct packed {
        logic [N_FIELDS-1:0][Q_W-1:0] q;
        logic [1:0]                   slot;
        logic                         neg;
        logic                         clamped;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/core/pqd_front.sv -----
// ----------------------------------------------------------------------------
// pqd_front
// Three-stage front end: scale the fields, square them, form the radicand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pqd_front import pqd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [PACKED_W-1:0] i_word,
    output logic                     o_valid,
    output t_sqrt                    o_sqrt,
    output t_side                    o_side
);

    logic [2:0]                    r_valid;
    logic [N_FIELDS-1:0][Q_W-1:0]  n_q;
    logic [N_FIELDS-1:0][Q_W-1:0]  r_q1;
    logic [N_FIELDS-1:0][Q_W-1:0]  r_q2;
    logic [N_FIELDS-1:0][SQ_W-1:0] n_sq;
    logic [N_FIELDS-1:0][SQ_W-1:0] r_sq;
    logic [1:0]                    r_slot1;
    logic [1:0]                    r_slot2;
    logic                          r_neg1;
    logic                          r_neg2;
    logic [SUM_W-1:0]              n_sum;
    logic                          n_clamped;
    logic [RAD_W-1:0]              n_rad;
    t_sqrt                         r_sqrt;
    t_side                         r_side;

    genvar g_lane;
    generate
        for (g_lane = 0; g_lane < N_FIELDS; g_lane++) begin : g_lanes
            logic signed [D_W-1:0]    d;
            logic signed [PROD_W-1:0] prod;
            logic signed [PROD_W-1:0] shifted;
            logic signed [2*Q_W-1:0]  sq;

            // Arithmetic shift of the biased product gives the floor.
            assign d       = $signed({1'b0, i_word[g_lane*FIELD_W +: FIELD_W]}) - FIELD_BIAS;
            assign prod    = PROD_W'(d) * SCALE_K + ROUND_HALF;
            assign shifted = prod >>> FRAC_SHIFT;
            assign n_q[g_lane] = shifted[Q_W-1:0];

            assign sq = $signed(r_q1[g_lane]) * $signed(r_q1[g_lane]);
            assign n_sq[g_lane] = sq[SQ_W-1:0];
        end
    endgenerate

    always_comb begin
        n_sum     = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        n_clamped = n_sum > ONE_Q28;
        n_rad     = n_clamped ? '0 : RAD_W'(ONE_Q28 - n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1           <= n_q;
        r_slot1        <= i_word[SLOT_LSB +: 2];
        r_neg1         <= i_word[NEG_BIT];
        r_q2           <= r_q1;
        r_sq           <= n_sq;
        r_slot2        <= r_slot1;
        r_neg2         <= r_neg1;
        r_sqrt.rem     <= SQRT_W'(n_rad);
        r_sqrt.root    <= '0;
        r_side.q       <= r_q2;
        r_side.slot    <= r_slot2;
        r_side.neg     <= r_neg2;
        r_side.clamped <= n_clamped;
    end

    assign o_valid = r_valid[2];
    assign o_sqrt  = r_sqrt;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ----- rtl/core/pqd_sqrt.sv -----
// ----------------------------------------------------------------------------
// pqd_sqrt
// Pipelined digit-by-digit integer square root, a few steps per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pqd_sqrt import pqd_pkg::*; #(
    parameter int P_STEPS = SQRT_STEPS_PER_STAGE
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_sqrt i_sqrt,
    input  wire t_side i_side,
    output logic       o_valid,
    output t_sqrt      o_sqrt,
    output t_side      o_side
);

    localparam int N_STAGES = (SQRT_STEPS + P_STEPS - 1) / P_STEPS;

    function automatic logic [SQRT_W-1:0] step_bit(input int idx);
        return SQRT_W'(1) << (SQRT_MSB - 2 * idx);
    endfunction

    // One restoring step: try root + bit against the remainder.
    function automatic t_sqrt sqrt_step(input t_sqrt st, input logic [SQRT_W-1:0] bv);
        t_sqrt             res;
        logic [SQRT_W-1:0] trial;
        trial = st.root + bv;
        if (st.rem >= trial) begin
            res.rem  = st.rem - trial;
            res.root = (st.root >> 1) + bv;
        end else begin
            res.rem  = st.rem;
            res.root = st.root >> 1;
        end
        return res;
    endfunction

    logic  v_q    [N_STAGES+1];
    t_sqrt sqrt_q [N_STAGES+1];
    t_side side_q [N_STAGES+1];

    assign v_q[0]    = i_valid;
    assign sqrt_q[0] = i_sqrt;
    assign side_q[0] = i_side;

    genvar g_st;
    generate
        for (g_st = 0; g_st < N_STAGES; g_st++) begin : g_stages
            t_sqrt n_sqrt;
            logic  r_valid;
            t_sqrt r_sqrt;
            t_side r_side;

            always_comb begin
                n_sqrt = sqrt_q[g_st];
                for (int j = 0; j < P_STEPS; j++) begin
                    if (g_st * P_STEPS + j < SQRT_STEPS) begin
                        n_sqrt = sqrt_step(n_sqrt, step_bit(g_st * P_STEPS + j));
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else begin
                    r_valid <= v_q[g_st];
                end
            end

            always_ff @(posedge i_clk) begin
                r_sqrt <= n_sqrt;
                r_side <= side_q[g_st];
            end

            assign v_q[g_st+1]    = r_valid;
            assign sqrt_q[g_st+1] = r_sqrt;
            assign side_q[g_st+1] = r_side;
        end
    endgenerate

    assign o_valid = v_q[N_STAGES];
    assign o_sqrt  = sqrt_q[N_STAGES];
    assign o_side  = side_q[N_STAGES];

endmodule

`default_nettype wire

// ----- rtl/core/pqd_place.sv -----
// ----------------------------------------------------------------------------
// pqd_place
// Rounds the root, applies the sign and places the four components.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pqd_place import pqd_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire t_sqrt                     i_sqrt,
    input  wire t_side                     i_side,
    output logic                           o_valid,
    output logic signed [COMP_W-1:0]       o_comp_x,
    output logic signed [COMP_W-1:0]       o_comp_y,
    output logic signed [COMP_W-1:0]       o_comp_z,
    output logic signed [COMP_W-1:0]       o_comp_w,
    output logic                           o_clamped
);

    logic [COMP_W-1:0]              w_mag;
    logic signed [COMP_W-1:0]       w_val;
    logic signed [COMP_W-1:0]       qa;
    logic signed [COMP_W-1:0]       qb;
    logic signed [COMP_W-1:0]       qc;
    logic [3:0][COMP_W-1:0]         n_slots;
    logic                           r_valid;
    logic [3:0][COMP_W-1:0]         r_slots;
    logic                           r_clamped;

    always_comb begin
        // Round to nearest: step up when the remainder exceeds the root.
        w_mag = COMP_W'(i_sqrt.root) + COMP_W'(i_sqrt.rem > i_sqrt.root);
        w_val = i_side.neg ? -$signed(w_mag) : $signed(w_mag);
        qa    = COMP_W'($signed(i_side.q[0]));
        qb    = COMP_W'($signed(i_side.q[1]));
        qc    = COMP_W'($signed(i_side.q[2]));
        unique case (i_side.slot)
            2'd0:    n_slots = {qc, qb, qa, w_val};
            2'd1:    n_slots = {qc, qb, w_val, qa};
            2'd2:    n_slots = {qc, w_val, qb, qa};
            default: n_slots = {w_val, qc, qb, qa};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slots   <= n_slots;
        r_clamped <= i_side.clamped;
    end

    assign o_valid   = r_valid;
    assign o_comp_x  = $signed(r_slots[0]);
    assign o_comp_y  = $signed(r_slots[1]);
    assign o_comp_z  = $signed(r_slots[2]);
    assign o_comp_w  = $signed(r_slots[3]);
    assign o_clamped = r_clamped;

endmodule

`default_nettype wire

// ----- rtl/core/packed_quaternion_decoder_40bit.sv -----
// ----------------------------------------------------------------------------
// packed_quaternion_decoder_40bit
// Smallest-three rotation decoder for one 40-bit packed word per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Signals                               Handshake
//  -------  ---------  ------------------------------------  ----------------
//  input    in         i_packed_value                        start && !busy
//  result   out        o_comp_x/y/z/w, o_radicand_clamped    o_valid strobe
//
// One word can be taken every clock cycle, so busy is held low. Each result
// appears on o_valid once its start transfer has passed 3 front-end stages,
// ceil(15 / P_SQRT_STEPS) square root stages and one output stage, with the
// default of four root steps per stage. The square root pipeline sets that
// depth. Reset is synchronous and clears only the valid bits; the receiver
// cannot stall, so results flow out unconditionally and nothing is held or
// dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed_quaternion_decoder_40bit import pqd_pkg::*; #(
    // Square root steps per pipeline stage, 1 to 8.
    parameter int P_SQRT_STEPS = SQRT_STEPS_PER_STAGE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [PACKED_W-1:0]   i_packed_value,
    output logic                       o_valid,
    output logic signed [COMP_W-1:0]   o_comp_x,
    output logic signed [COMP_W-1:0]   o_comp_y,
    output logic signed [COMP_W-1:0]   o_comp_z,
    output logic signed [COMP_W-1:0]   o_comp_w,
    output logic                       o_radicand_clamped
);

    localparam int SQRT_STAGES = (SQRT_STEPS + P_SQRT_STEPS - 1) / P_SQRT_STEPS;
    localparam int LATENCY     = 3 + SQRT_STAGES + 1;

    logic  front_valid;
    t_sqrt front_sqrt;
    t_side front_side;
    logic  root_valid;
    t_sqrt root_sqrt;
    t_side root_side;

    // The pipeline never backs up, so every start is a transfer.
    assign busy = 1'b0;

    // Stages 1 to 3: scale the three fields, square them, and form the
    // clamped radicand 1.0 - sum of squares in Q2.28.
    pqd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_word  (i_packed_value),
        .o_valid (front_valid),
        .o_sqrt  (front_sqrt),
        .o_side  (front_side)
    );

    // Fifteen restoring square root steps, spread over the root stages.
    // The scaled components, slot and sign travel along with each word.
    pqd_sqrt #(
        .P_STEPS (P_SQRT_STEPS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_sqrt  (front_sqrt),
        .i_side  (front_side),
        .o_valid (root_valid),
        .o_sqrt  (root_sqrt),
        .o_side  (root_side)
    );

    // Final stage: round the root, negate it if asked, and put it into its
    // slot while the three decoded components fill the others in order.
    pqd_place u_place (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (root_valid),
        .i_sqrt    (root_sqrt),
        .i_side    (root_side),
        .o_valid   (o_valid),
        .o_comp_x  (o_comp_x),
        .o_comp_y  (o_comp_y),
        .o_comp_z  (o_comp_z),
        .o_comp_w  (o_comp_w),
        .o_clamped (o_radicand_clamped)
    );

`ifndef SYNTHESIS
    // Every result strobe goes back to a matching earlier start.
    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without matching start");

    // A clamped radicand leaves a zero in the slot of the computed component.
    a_clamp_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_radicand_clamped) |->
            (o_comp_x == 0 || o_comp_y == 0 || o_comp_z == 0 || o_comp_w == 0))
        else $error("clamped radicand but no zero component");

    // All components stay within plus or minus 1.0 in Q1.14.
    a_comp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_comp_x >= -16384 && o_comp_x <= 16384 &&
                     o_comp_y >= -16384 && o_comp_y <= 16384 &&
                     o_comp_z >= -16384 && o_comp_z <= 16384 &&
                     o_comp_w >= -16384 && o_comp_w <= 16384))
        else $error("component out of Q1.14 unit range");
`endif

endmodule

`default_nettype wire

// ----- verif/packed_quaternion_decoder_40bit_tb.sv -----
// ----------------------------------------------------------------------------
// packed_quaternion_decoder_40bit_tb
// Self-checking bench for the smallest-three rotation decoder.
// Every accepted word is decoded by a behavioral model inside the bench. The
// expected rotation is queued, and each o_valid strobe is compared field by
// field against the oldest entry. Directed words cover the field extremes,
// every slot with both signs, the ignored top bit and words on both sides of
// the unit sphere. A long random run with varied input gaps follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_quaternion_decoder_40bit_tb;
    import pqd_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          RANDOM_WORDS = 1500;

    // Decoder arithmetic: d = field - bias, q = floor((d * K + half) / 2^18).
    localparam longint      FIELD_OFFSET = 2049;
    localparam longint      SCALE_Q0_32  = 1483636;
    localparam longint      ROUND_HALF   = 131072;
    localparam int          SCALE_SHIFT  = 18;
    localparam longint      UNIT_Q2_28   = 64'd268435456;
    localparam int          ROOT_BITS    = 15;

    // Gap styles used by the random run.
    typedef enum int {GAPS_NONE, GAPS_UNIFORM, GAPS_RARE} t_gap_style;
    // Content styles used by the random run.
    typedef enum int {WORD_RAW, WORD_CENTERED, WORD_ON_SPHERE} t_word_style;

    typedef struct {
        logic signed [COMP_W-1:0] comp [4];
        logic                     clamped;
    } t_rotation;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [PACKED_W-1:0]       i_packed_value = '0;
    logic                      busy;
    logic                      o_valid;
    logic signed [COMP_W-1:0]  o_comp_x;
    logic signed [COMP_W-1:0]  o_comp_y;
    logic signed [COMP_W-1:0]  o_comp_z;
    logic signed [COMP_W-1:0]  o_comp_w;
    logic                      o_radicand_clamped;

    t_rotation pending_rotations [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    string     comp_names [4] = '{"comp_x", "comp_y", "comp_z", "comp_w"};

    packed_quaternion_decoder_40bit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_packed_value     (i_packed_value),
        .o_valid            (o_valid),
        .o_comp_x           (o_comp_x),
        .o_comp_y           (o_comp_y),
        .o_comp_z           (o_comp_z),
        .o_comp_w           (o_comp_w),
        .o_radicand_clamped (o_radicand_clamped)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Behavioral model of the decoder.
    // ------------------------------------------------------------------------

    // One 12-bit field to a signed Q1.14 component. The arithmetic shift of
    // a signed value floors, which matches the round-half-up rule.
    function automatic longint scale_component(input logic [FIELD_W-1:0] field);
        longint d;
        d = longint'(field) - FIELD_OFFSET;
        return (d * SCALE_Q0_32 + ROUND_HALF) >>> SCALE_SHIFT;
    endfunction

    function automatic longint sum_of_squares(input logic [FIELD_W-1:0] fa,
                                              input logic [FIELD_W-1:0] fb,
                                              input logic [FIELD_W-1:0] fc);
        longint qa, qb, qc;
        qa = scale_component(fa);
        qb = scale_component(fb);
        qc = scale_component(fc);
        return qa * qa + qb * qb + qc * qc;
    endfunction

    // Square root rounded to nearest, ties up: the floor root is bumped when
    // the remainder exceeds the root itself.
    function automatic longint rounded_root(input longint radicand);
        longint root, trial;
        int     b;
        root = 0;
        for (b = ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (64'sd1 <<< b);
            if (trial * trial <= radicand)
                root = trial;
        end
        if (radicand - root * root > root)
            root = root + 1;
        return root;
    endfunction

    function automatic t_rotation predict_rotation(input logic [PACKED_W-1:0] word);
        t_rotation rot;
        longint    abc [3];
        longint    sum, radicand, w;
        int        slot, src, j;
        for (j = 0; j < N_FIELDS; j++)
            abc[j] = scale_component(word[j*FIELD_W +: FIELD_W]);
        sum = abc[0] * abc[0] + abc[1] * abc[1] + abc[2] * abc[2];
        // A point outside the unit sphere has no real fourth component.
        rot.clamped = (sum > UNIT_Q2_28);
        radicand = rot.clamped ? 0 : UNIT_Q2_28 - sum;
        w = rounded_root(radicand);
        if (word[NEG_BIT])
            w = -w;
        slot = int'(word[SLOT_LSB +: 2]);
        src = 0;
        // The computed component takes its slot; the stored three keep
        // their order around it.
        for (j = 0; j < 4; j++) begin
            if (j == slot) begin
                rot.comp[j] = w[COMP_W-1:0];
            end else begin
                rot.comp[j] = abc[src][COMP_W-1:0];
                src++;
            end
        end
        return rot;
    endfunction

    function automatic logic [PACKED_W-1:0] pack_rotation(input logic [FIELD_W-1:0] fa,
                                                          input logic [FIELD_W-1:0] fb,
                                                          input logic [FIELD_W-1:0] fc,
                                                          input logic [1:0]         slot,
                                                          input logic               neg,
                                                          input logic               spare);
        return {spare, neg, slot, fc, fb, fa};
    endfunction

    // Picks the third field that brings the radicand closest to zero for the
    // first two, so the word lands right at the unit sphere. When the first
    // two already overshoot, any third field clamps.
    function automatic logic [FIELD_W-1:0] field_near_sphere(input logic [FIELD_W-1:0] fa,
                                                             input logic [FIELD_W-1:0] fb);
        longint              qa, qb, rest, target, d0, d, err, best_err;
        logic [FIELD_W-1:0]  best, cand;
        int                  delta, sgn;
        qa = scale_component(fa);
        qb = scale_component(fb);
        rest = UNIT_Q2_28 - qa * qa - qb * qb;
        if (rest < 0)
            return FIELD_W'($urandom_range(0, 4095));
        target = rounded_root(rest);
        d0 = (target <<< SCALE_SHIFT) / SCALE_Q0_32;
        sgn = $urandom_range(0, 1) ? 1 : -1;
        best = FIELD_W'(FIELD_OFFSET);
        best_err = rest;
        for (delta = -2; delta <= 2; delta++) begin
            d = FIELD_OFFSET + sgn * (d0 + delta);
            if (d >= 0 && d <= 4095) begin
                cand = FIELD_W'(d);
                err = UNIT_Q2_28 - sum_of_squares(fa, fb, cand);
                if (err < 0)
                    err = -err;
                if (err < best_err) begin
                    best_err = err;
                    best = cand;
                end
            end
        end
        return best;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------------

    // Presents one word and holds it until the decoder takes it. The
    // expectation is queued on the edge of the transfer. Start is only
    // lowered when a gap follows, so back-to-back words never see a glitch.
    task automatic send_word(input logic [PACKED_W-1:0] word, input int unsigned gap);
        start <= 1'b1;
        i_packed_value <= word;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_rotations.push_back(predict_rotation(word));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Field extremes: lowest and highest raw values and the bias point,
    // where all three components are zero and the fourth is exactly 1.0.
    task automatic test_field_extremes();
        send_word(pack_rotation(12'h000, 12'h000, 12'h000, 2'd0, 1'b0, 1'b0), 0);
        send_word(pack_rotation(12'hFFF, 12'hFFF, 12'hFFF, 2'd3, 1'b1, 1'b1), 0);
        send_word(pack_rotation(12'hFFF, 12'h000, 12'hFFF, 2'd1, 1'b0, 1'b0), 1);
        send_word(pack_rotation(12'd2049, 12'd2049, 12'd2049, 2'd0, 1'b0, 1'b0), 0);
        send_word(pack_rotation(12'd2049, 12'd2049, 12'd2049, 2'd2, 1'b1, 1'b0), 2);
        send_word(pack_rotation(12'h000, 12'd2049, 12'd2049, 2'd3, 1'b0, 1'b0), 0);
    endtask

    // Every slot index with both signs, using small distinct components so
    // that each one can be traced to its output port.
    task automatic test_slot_placement();
        int s, n;
        for (s = 0; s < 4; s++) begin
            for (n = 0; n < 2; n++)
                send_word(pack_rotation(12'd2349, 12'd1649, 12'd2949, 2'(s), 1'(n), 1'b0),
                          $urandom_range(0, 2));
        end
    endtask

    // Words just inside and just outside the unit sphere. An exact zero
    // radicand cannot be packed, so the closest word on each side stands in.
    // The overshoot is sent again with the sign bit to negate a clamped zero.
    task automatic test_sphere_boundary();
        logic [PACKED_W-1:0] inside_word, outside_word;
        longint              inside_gap, outside_gap, r;
        logic [FIELD_W-1:0]  fa, fb, fc;
        int                  k;
        inside_gap = UNIT_Q2_28;
        outside_gap = UNIT_Q2_28;
        inside_word = '0;
        outside_word = '0;
        for (k = 0; k < 4096; k += 5) begin
            fa = FIELD_W'(k);
            fb = FIELD_W'(4095 - k / 2);
            fc = field_near_sphere(fa, fb);
            r = UNIT_Q2_28 - sum_of_squares(fa, fb, fc);
            if (r >= 0 && r < inside_gap) begin
                inside_gap = r;
                inside_word = pack_rotation(fa, fb, fc, 2'd1, 1'b0, 1'b0);
            end
            if (r < 0 && -r < outside_gap) begin
                outside_gap = -r;
                outside_word = pack_rotation(fa, fb, fc, 2'd2, 1'b0, 1'b0);
            end
        end
        send_word(inside_word, 0);
        send_word(outside_word, 0);
        outside_word[NEG_BIT] = 1'b1;
        send_word(outside_word, 3);
    endtask

    // The top bit of the word carries nothing; both values must decode alike.
    task automatic test_ignored_bit();
        send_word(pack_rotation(12'd1500, 12'd2600, 12'd2100, 2'd2, 1'b1, 1'b0), 0);
        send_word(pack_rotation(12'd1500, 12'd2600, 12'd2100, 2'd2, 1'b1, 1'b1), 0);
    endtask

    // Random words in phases of 100. Each phase has its own gap style, so
    // gaps land on every stage of the pipeline and long unbroken bursts
    // occur as well. Content mixes raw words, words near the bias point
    // (never clamped) and words right on the unit sphere.
    task automatic test_random_words(input int count);
        logic [PACKED_W-1:0] word;
        logic [FIELD_W-1:0]  fa, fb, fc;
        t_gap_style          gaps;
        t_word_style         content;
        int unsigned         gap;
        int                  i;
        gaps = GAPS_NONE;
        for (i = 0; i < count; i++) begin
            if (i % 100 == 0)
                gaps = t_gap_style'($urandom_range(0, 2));
            content = t_word_style'($urandom_range(0, 2));
            case (content)
                WORD_RAW: begin
                    word = PACKED_W'({$urandom, $urandom});
                end
                WORD_CENTERED: begin
                    fa = FIELD_W'($urandom_range(849, 3249));
                    fb = FIELD_W'($urandom_range(849, 3249));
                    fc = FIELD_W'($urandom_range(849, 3249));
                    word = pack_rotation(fa, fb, fc, 2'($urandom), 1'($urandom),
                                         1'($urandom));
                end
                default: begin
                    fa = FIELD_W'($urandom);
                    fb = FIELD_W'($urandom);
                    fc = field_near_sphere(fa, fb);
                    word = pack_rotation(fa, fb, fc, 2'($urandom), 1'($urandom),
                                         1'($urandom));
                end
            endcase
            case (gaps)
                GAPS_NONE:    gap = 0;
                GAPS_UNIFORM: gap = $urandom_range(0, 7);
                default:      gap = ($urandom_range(0, 9) == 0) ? 7 : 0;
            endcase
            send_word(word, gap);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking. The receiver cannot stall, so every strobe is a
    // transfer and is compared against the oldest queued rotation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rotation               want;
        logic signed [COMP_W-1:0] got [4];
        if (i_rst_n && o_valid) begin
            if (pending_rotations.size() == 0) begin
                $error("result transfer with no word outstanding");
                mismatch_count++;
            end else begin
                want = pending_rotations.pop_front();
                got = '{o_comp_x, o_comp_y, o_comp_z, o_comp_w};
                for (int j = 0; j < 4; j++) begin
                    if (got[j] !== want.comp[j]) begin
                        $error("%s mismatch: expected %0d, actual %0d",
                               comp_names[j], want.comp[j], got[j]);
                        mismatch_count++;
                    end
                end
                if (o_radicand_clamped !== want.clamped) begin
                    $error("radicand_clamped mismatch: expected %0b, actual %0b",
                           want.clamped, o_radicand_clamped);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_slot_placement();
        test_sphere_boundary();
        test_ignored_bit();
        test_random_words(RANDOM_WORDS);

        start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge i_clk);
        // Any extra strobe after the last expected result shows up here.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_rotations.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
